>>> hw/rtl/msi_pkg.sv
// Shared types and constants for the MSI snooping coherence controller.
// No dependencies; imported by the interfaces and all controller modules.
package msi_pkg;

    localparam int LINE_COUNT = 1024;
    localparam int LINE_AW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int ADDR_W     = 10;
    localparam int REQ_W      = 4;
    localparam int MISS_W     = 32;

    typedef enum logic [2:0] {
        K_LOAD  = 3'd0,
        K_STORE = 3'd1,
        K_GETS  = 3'd2,
        K_GETM  = 3'd3,
        K_DATA  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_GETS = 3'd1,
        ACT_GETM = 3'd2,
        ACT_PROC = 3'd3,
        ACT_BUS  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        LS_I  = 3'd0,
        LS_S  = 3'd1,
        LS_M  = 3'd2,
        LS_SM = 3'd3,
        LS_IM = 3'd4,
        LS_IS = 3'd5
    } t_line;

    typedef struct packed {
        logic clr;
        logic accept;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

>>> hw/rtl/msi_req_if.sv
// Request channel: processor requests and snooped bus messages.
// Depends on msi_pkg.
interface msi_req_if;
    import msi_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [ADDR_W-1:0] line_address;
    logic [REQ_W-1:0]  requester_id;

    modport source (output valid, kind, line_address, requester_id, input ready);
    modport sink   (input valid, kind, line_address, requester_id, output ready);
endinterface

>>> hw/rtl/msi_rsp_if.sv
// Response channel: action, snoop reply, new line state and miss count.
// Depends on msi_pkg.
interface msi_rsp_if;
    import msi_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [ADDR_W-1:0] action_address;
    logic [REQ_W-1:0]  data_destination;
    logic              assert_shared;
    logic [2:0]        line_state_after;
    logic              protocol_error;
    logic [MISS_W-1:0] miss_total;

    modport source (output valid, action, action_address, data_destination, assert_shared,
                    line_state_after, protocol_error, miss_total, input ready);
    modport sink   (input valid, action, action_address, data_destination, assert_shared,
                    line_state_after, protocol_error, miss_total, output ready);
endinterface

>>> hw/rtl/msi_snoop_coherence_controller_core.sv
// MSI snooping coherence controller, top level.
// An accepted request word is registered together with its table read; in execute
// the MSI result is written to the output register, from which it can be taken.
// A new word is accepted only once the previous one has left execute; a result held
// by the sink keeps the next word in execute, so ready stays low until it drains.
// Reset: synchronous; a sweep then sets every line to I, with ready low until it ends.
module msi_snoop_coherence_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msi_req_if.sink     i_req,
    msi_rsp_if.source   o_rsp
);
    import msi_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    msi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    msi_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_kind             (i_req.kind),
        .i_line_address     (i_req.line_address),
        .i_requester_id     (i_req.requester_id),
        .o_action           (o_rsp.action),
        .o_action_address   (o_rsp.action_address),
        .o_data_destination (o_rsp.data_destination),
        .o_assert_shared    (o_rsp.assert_shared),
        .o_line_state_after (o_rsp.line_state_after),
        .o_protocol_error   (o_rsp.protocol_error),
        .o_miss_total       (o_rsp.miss_total)
    );

endmodule

>>> hw/rtl/msi_ctrl.sv
// Control FSM: clear sweep, accept, execute and output word handshake.
// Depends on msi_pkg.
module msi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msi_pkg::t_dp_cmd  o_cmd,
    input  msi_pkg::t_dp_sts  i_sts
);
    import msi_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, exec_go;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign exec_go     = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.clr    = (r_state == ST_CLEAR);
    assign o_cmd.accept = accept;
    assign o_cmd.exec   = exec_go;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted word did not enter execute");

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_EXEC))
        else $error("output word raised outside execute");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !exec_go)
        else $error("result overwrote a pending output word");

endmodule

>>> hw/rtl/msi_dp.sv
// Datapath: line state table, MSI transition, miss counter, output register.
// Depends on msi_pkg.
module msi_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  msi_pkg::t_dp_cmd          i_cmd,
    output msi_pkg::t_dp_sts          o_sts,
    input  logic [2:0]                i_kind,
    input  logic [msi_pkg::ADDR_W-1:0] i_line_address,
    input  logic [msi_pkg::REQ_W-1:0] i_requester_id,
    output logic [2:0]                o_action,
    output logic [msi_pkg::ADDR_W-1:0] o_action_address,
    output logic [msi_pkg::REQ_W-1:0] o_data_destination,
    output logic                      o_assert_shared,
    output logic [2:0]                o_line_state_after,
    output logic                      o_protocol_error,
    output logic [msi_pkg::MISS_W-1:0] o_miss_total
);
    import msi_pkg::*;

    t_line              r_mem [LINE_COUNT];
    t_line              r_rd;
    logic [2:0]         r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic [REQ_W-1:0]   r_req;
    logic               r_inrange;
    logic [LINE_AW-1:0] r_clr_idx;
    logic [MISS_W-1:0]  r_miss, n_miss;

    t_action            r_act;
    logic [ADDR_W-1:0]  r_act_addr;
    logic [REQ_W-1:0]   r_dest;
    logic               r_shared;
    t_line              r_lsa;
    logic               r_err;

    t_line              nx;
    t_action            act;
    logic               shared, err, miss_inc;
    logic               in_range, wr_en;
    logic [LINE_AW-1:0] wr_idx;
    t_line              wr_data;

    assign in_range = (32'(i_line_address) < LINE_COUNT);
    assign o_sts.clr_last = (r_clr_idx == LINE_AW'(LINE_COUNT - 1));

    always_comb begin
        nx       = r_rd;
        act      = ACT_NONE;
        shared   = 1'b0;
        err      = 1'b0;
        miss_inc = 1'b0;
        case (r_kind)
            K_LOAD, K_STORE: begin
                case (r_rd)
                    LS_I: begin
                        act      = (r_kind == K_LOAD) ? ACT_GETS : ACT_GETM;
                        nx       = (r_kind == K_LOAD) ? LS_IS : LS_IM;
                        miss_inc = 1'b1;
                    end
                    LS_S: begin
                        if (r_kind == K_LOAD) begin
                            act = ACT_PROC;
                        end else begin
                            act      = ACT_GETM;
                            nx       = LS_SM;
                            miss_inc = 1'b1;
                        end
                    end
                    LS_M:    act = ACT_PROC;
                    default: ;
                endcase
            end
            K_GETS, K_GETM, K_DATA: begin
                case (r_rd)
                    LS_S: begin
                        if (r_kind == K_GETS) begin
                            shared = 1'b1;
                        end else if (r_kind == K_GETM) begin
                            nx = LS_I;
                        end
                    end
                    LS_M: begin
                        if (r_kind == K_DATA) begin
                            err = 1'b1;
                        end else begin
                            shared = 1'b1;
                            act    = ACT_BUS;
                            nx     = (r_kind == K_GETS) ? LS_S : LS_I;
                        end
                    end
                    LS_SM, LS_IM: begin
                        if (r_kind == K_DATA) begin
                            act = ACT_PROC;
                            nx  = LS_M;
                        end
                    end
                    LS_IS: begin
                        if (r_kind == K_DATA) begin
                            act = ACT_PROC;
                            nx  = LS_S;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign n_miss  = r_miss + MISS_W'(miss_inc && r_inrange);
    assign wr_en   = i_cmd.clr || (i_cmd.exec && r_inrange);
    assign wr_idx  = i_cmd.clr ? r_clr_idx : r_addr[LINE_AW-1:0];
    assign wr_data = i_cmd.clr ? LS_I : nx;

    // state table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_idx] <= wr_data;
        if (i_cmd.accept) r_rd <= r_mem[i_line_address[LINE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_kind;
            r_addr    <= i_line_address;
            r_req     <= i_requester_id;
            r_inrange <= in_range;
        end
        if (i_cmd.exec) begin
            if (r_inrange) begin
                r_act      <= act;
                r_act_addr <= (act != ACT_NONE) ? r_addr : '0;
                r_dest     <= (act == ACT_BUS) ? r_req : '0;
                r_shared   <= shared;
                r_lsa      <= nx;
                r_err      <= err;
            end else begin
                r_act      <= ACT_NONE;
                r_act_addr <= '0;
                r_dest     <= '0;
                r_shared   <= 1'b0;
                r_lsa      <= LS_I;
                r_err      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_miss    <= '0;
        end else begin
            if (i_cmd.clr) r_clr_idx <= r_clr_idx + LINE_AW'(1);
            if (i_cmd.exec) r_miss <= n_miss;
        end
    end

    assign o_action           = r_act;
    assign o_action_address   = r_act_addr;
    assign o_data_destination = r_dest;
    assign o_assert_shared    = r_shared;
    assign o_line_state_after = r_lsa;
    assign o_protocol_error   = r_err;
    assign o_miss_total       = r_miss;

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cmd.exec) |-> $stable(r_miss))
        else $error("miss count changed without an executed word");

    a_err_in_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec) && r_err |-> (r_act == ACT_NONE) && (r_lsa == LS_M))
        else $error("protocol error reported outside M");

    a_bus_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec) && (r_act != ACT_BUS) |-> (r_dest == '0))
        else $error("data destination set without bus data");

endmodule

>>> dv/testbench.sv
// Testbench for msi_snoop_coherence_controller_core: a directed table, then random
// processor and snoop words, results checked against a line-state predictor or typed rows.
// Depends on msi_pkg, msi_req_if, msi_rsp_if and the controller RTL.
`timescale 1ns / 100ps

module testbench;
    import msi_pkg::*;

    localparam logic [2:0] K_RSVD_LO   = 3'd5;
    localparam logic [2:0] K_RSVD_HI   = 3'd7;
    localparam int         RAND_WORDS  = 1400;
    localparam int         HOLD_CYCLES = 120;
    localparam int         HOT_LINES   = 8;

    typedef struct packed {
        t_action           action;
        logic [ADDR_W-1:0] addr;
        logic [REQ_W-1:0]  dest;
        logic              shared;
        t_line             state;
        logic              err;
        logic [MISS_W-1:0] miss;
    } t_line_result;

    typedef struct packed {
        logic         typed;
        t_line_result exp;
    } t_word_note;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [REQ_W-1:0]  req;
        t_word_note        note;
    } t_stim_row;

    localparam t_word_note PREDICTED = '0;
    localparam t_line_result IDLE_FRESH =
        '{ACT_NONE, 10'd0, 4'd0, 1'b0, LS_I, 1'b0, 32'd0};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    msi_req_if req_if();
    msi_rsp_if rsp_if();

    msi_snoop_coherence_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_line             line_tbl [LINE_COUNT];
    logic [MISS_W-1:0] miss_count = '0;
    t_line_result      line_results_q [$];
    t_word_note        word_notes [$];
    int                words_sent  = 0;
    int                words_in    = 0;
    int                outstanding = 0;
    int                fails       = 0;
    bit                src_jitter  = 1'b1;
    bit                sink_jitter = 1'b1;
    bit                sink_hold   = 1'b0;

    t_stim_row dir_rows [25] = '{
        '{K_GETS,    10'd0,    4'd15, '{1'b1, IDLE_FRESH}},
        '{K_DATA,    10'd1023, 4'd0,  '{1'b1, IDLE_FRESH}},
        '{K_GETM,    10'd1023, 4'd15, '{1'b1, IDLE_FRESH}},
        '{K_RSVD_HI, 10'd5,    4'd15, '{1'b1, IDLE_FRESH}},
        '{K_LOAD,    10'd0,    4'd0,
          '{1'b1, '{ACT_GETS, 10'd0, 4'd0, 1'b0, LS_IS, 1'b0, 32'd1}}},
        '{K_LOAD,    10'd0,    4'd1,  PREDICTED},
        '{K_STORE,   10'd0,    4'd2,  PREDICTED},
        '{K_GETM,    10'd0,    4'd4,  PREDICTED},
        '{K_DATA,    10'd0,    4'd3,  PREDICTED},
        '{K_LOAD,    10'd0,    4'd0,  PREDICTED},
        '{K_GETS,    10'd0,    4'd9,  PREDICTED},
        '{K_DATA,    10'd0,    4'd8,  PREDICTED},
        '{K_STORE,   10'd0,    4'd0,  PREDICTED},
        '{K_LOAD,    10'd0,    4'd0,  PREDICTED},
        '{K_DATA,    10'd0,    4'd6,  PREDICTED},
        '{K_DATA,    10'd0,    4'd7,
          '{1'b1, '{ACT_NONE, 10'd0, 4'd0, 1'b0, LS_M, 1'b1, 32'd2}}},
        '{K_LOAD,    10'd0,    4'd0,  PREDICTED},
        '{K_STORE,   10'd0,    4'd0,  PREDICTED},
        '{K_GETS,    10'd0,    4'd15,
          '{1'b1, '{ACT_BUS, 10'd0, 4'd15, 1'b1, LS_S, 1'b0, 32'd2}}},
        '{K_GETM,    10'd0,    4'd0,  PREDICTED},
        '{K_STORE,   10'd1023, 4'd5,  PREDICTED},
        '{K_GETS,    10'd1023, 4'd5,  PREDICTED},
        '{K_DATA,    10'd1023, 4'd12, PREDICTED},
        '{K_GETM,    10'd1023, 4'd10, PREDICTED},
        '{K_RSVD_LO, 10'd1023, 4'd15, PREDICTED}
    };

    initial begin
        for (int i = 0; i < LINE_COUNT; i++) begin
            line_tbl[i] = LS_I;
        end
    end

    // MSI transition for one word; updates the shadow line table and miss count
    function automatic t_line_result next_line_result(input logic [2:0] kind,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [REQ_W-1:0] req);
        t_line_result res;
        t_line        st;
        t_line        nx;
        res = '0;
        if (addr >= LINE_COUNT) begin
            res.miss = miss_count;
            return res;
        end
        st = line_tbl[addr];
        nx = st;
        res.action = ACT_NONE;
        case (kind)
            K_LOAD, K_STORE: begin
                case (st)
                    LS_I: begin
                        miss_count = miss_count + MISS_W'(1);
                        if (kind == K_LOAD) begin
                            res.action = ACT_GETS;
                            nx = LS_IS;
                        end else begin
                            res.action = ACT_GETM;
                            nx = LS_IM;
                        end
                    end
                    LS_S: begin
                        if (kind == K_LOAD) begin
                            res.action = ACT_PROC;
                        end else begin
                            res.action = ACT_GETM;
                            nx = LS_SM;
                            miss_count = miss_count + MISS_W'(1);
                        end
                    end
                    LS_M: res.action = ACT_PROC;
                    default: ;
                endcase
            end
            K_GETS, K_GETM, K_DATA: begin
                case (st)
                    LS_S: begin
                        if (kind == K_GETS) res.shared = 1'b1;
                        else if (kind == K_GETM) nx = LS_I;
                    end
                    LS_M: begin
                        if (kind == K_DATA) begin
                            res.err = 1'b1;
                        end else begin
                            res.shared = 1'b1;
                            res.action = ACT_BUS;
                            nx = (kind == K_GETS) ? LS_S : LS_I;
                        end
                    end
                    LS_SM, LS_IM: begin
                        if (kind == K_DATA) begin
                            res.action = ACT_PROC;
                            nx = LS_M;
                        end
                    end
                    LS_IS: begin
                        if (kind == K_DATA) begin
                            res.action = ACT_PROC;
                            nx = LS_S;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        line_tbl[addr] = nx;
        res.state = nx;
        res.addr = (res.action != ACT_NONE) ? addr : '0;
        res.dest = (res.action == ACT_BUS) ? req : '0;
        res.miss = miss_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : line_monitor
        t_line_result want;
        t_word_note   note;
        bit           acc;
        bit           popped;
        acc = (req_if.valid === 1'b1) && (req_if.ready === 1'b1);
        popped = 1'b0;
        if ((rsp_if.valid === 1'b1) && (rsp_if.ready === 1'b1)) begin
            if (line_results_q.size() == 0) begin
                $display("%0t: result word with no expectation, expected none, actual %0h",
                         $time, rsp_if.action);
                fails++;
            end else begin
                want = line_results_q.pop_front();
                popped = 1'b1;
                check_field("action", 32'(want.action), 32'(rsp_if.action));
                check_field("action_address", 32'(want.addr), 32'(rsp_if.action_address));
                check_field("data_destination", 32'(want.dest),
                            32'(rsp_if.data_destination));
                check_field("assert_shared", 32'(want.shared), 32'(rsp_if.assert_shared));
                check_field("line_state_after", 32'(want.state),
                            32'(rsp_if.line_state_after));
                check_field("protocol_error", 32'(want.err), 32'(rsp_if.protocol_error));
                check_field("miss_total", want.miss, rsp_if.miss_total);
            end
        end
        if (acc) begin
            note = (word_notes.size() != 0) ? word_notes.pop_front() : PREDICTED;
            want = next_line_result(req_if.kind, req_if.line_address, req_if.requester_id);
            line_results_q.push_back(note.typed ? note.exp : want);
        end
        words_in <= words_in + int'(acc);
        outstanding <= outstanding + int'(acc) - int'(popped);
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold) begin
                rsp_if.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
                sink_hold = 1'b0;
            end else begin
                rsp_if.ready <= !sink_jitter || ($urandom_range(99) >= 25);
            end
        end
    end

    task automatic put_word(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [REQ_W-1:0] req, input t_word_note note);
        while (src_jitter && $urandom_range(99) < 25) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_notes.push_back(note);
        req_if.valid        <= 1'b1;
        req_if.kind         <= kind;
        req_if.line_address <= addr;
        req_if.requester_id <= req;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (words_in != words_sent || outstanding != 0);
    endtask

    initial begin
        logic [ADDR_W-1:0] hot [HOT_LINES];
        logic [2:0]        kind;
        logic [ADDR_W-1:0] addr;
        int                roll;
        req_if.valid        <= 1'b0;
        req_if.kind         <= K_LOAD;
        req_if.line_address <= '0;
        req_if.requester_id <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            put_word(dir_rows[i].kind, dir_rows[i].addr, dir_rows[i].req, dir_rows[i].note);
        end
        drain_results();

        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i % 200 == 0) begin
                foreach (hot[h]) hot[h] = ADDR_W'($urandom_range(LINE_COUNT - 1));
                if (i == 0) begin
                    hot[0] = '0;
                    hot[1] = ADDR_W'(LINE_COUNT - 1);
                end
            end
            if (i == 200) begin
                src_jitter  = 1'b1;
                sink_jitter = 1'b1;
            end
            if (i == 600) sink_hold = 1'b1;
            if (i == 1000) drain_results();
            roll = $urandom_range(99);
            if (roll < 24) kind = K_LOAD;
            else if (roll < 44) kind = K_STORE;
            else if (roll < 58) kind = K_GETS;
            else if (roll < 72) kind = K_GETM;
            else if (roll < 96) kind = K_DATA;
            else kind = 3'($urandom_range(K_RSVD_HI, K_RSVD_LO));
            addr = ($urandom_range(99) < 80) ? hot[3'($urandom_range(HOT_LINES - 1))]
                                             : ADDR_W'($urandom_range(LINE_COUNT - 1));
            put_word(kind, addr, REQ_W'($urandom_range(15)), PREDICTED);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/msi_pkg.sv
hw/rtl/msi_req_if.sv
hw/rtl/msi_rsp_if.sv
hw/rtl/msi_ctrl.sv
hw/rtl/msi_dp.sv
hw/rtl/msi_snoop_coherence_controller_core.sv
dv/testbench.sv
